### sv/m3i_pkg.sv
// m3i_pkg: word types, widths, cofactor index tables and the Q16.16 saturation
// helper for the 3x3 matrix inverse. No dependencies.
`default_nettype none

package m3i_pkg;

    localparam int EW           = 32;           // element width, Q16.16
    localparam int CMW          = 64;           // cofactor magnitude width
    localparam int DMW          = 96;           // determinant magnitude width
    localparam int QBITS        = 32;           // quotient bits per lane
    localparam int NLANE        = 9;            // one divider lane per element
    localparam int FRONT_STAGES = 10;
    localparam int DIV_STAGES   = QBITS;

    localparam logic [EW-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [EW-1:0] Q_MIN = 32'h8000_0000;

    // cofactor k = a[CX]*a[CY] - a[CU]*a[CV], row-major element index
    localparam int unsigned CX [NLANE] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
    localparam int unsigned CY [NLANE] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
    localparam int unsigned CU [NLANE] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
    localparam int unsigned CV [NLANE] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

    typedef struct packed {
        logic signed [EW-1:0] a00;
        logic signed [EW-1:0] a01;
        logic signed [EW-1:0] a02;
        logic signed [EW-1:0] a10;
        logic signed [EW-1:0] a11;
        logic signed [EW-1:0] a12;
        logic signed [EW-1:0] a20;
        logic signed [EW-1:0] a21;
        logic signed [EW-1:0] a22;
    } mat_t;

    typedef struct packed {
        logic signed [EW-1:0] r00;
        logic signed [EW-1:0] r01;
        logic signed [EW-1:0] r02;
        logic signed [EW-1:0] r10;
        logic signed [EW-1:0] r11;
        logic signed [EW-1:0] r12;
        logic signed [EW-1:0] r20;
        logic signed [EW-1:0] r21;
        logic signed [EW-1:0] r22;
        logic signed [EW-1:0] determinant;
        logic                 singular;
    } inv_t;

    typedef struct packed {
        logic [CMW-1:0] mag;
        logic           neg;
    } cof_t;

    // what the front end hands each divider lane
    typedef struct packed {
        logic [DMW-1:0] rem;
        logic           qneg;
        logic           ovf;
    } lane_in_t;

    // sign plus magnitude to Q16.16; big flags magnitude bits above the 32 given
    function automatic logic [EW-1:0] sat_q(input logic neg, input logic big,
                                            input logic [EW-1:0] mag);
        logic [EW-1:0] r;
        if (big)
            r = neg ? Q_MIN : Q_MAX;
        else if (neg)
            r = (mag > Q_MIN) ? Q_MIN : EW'(-mag);
        else
            r = (mag > Q_MAX) ? Q_MAX : mag;
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/matrix3x3_inverse.sv
// matrix3x3_inverse: top level, front end, nine divider lanes, result merge
// and output skid. Depends on m3i_pkg, m3i_front, m3i_lane.
//
// Usage
//   mat channel: one 3x3 Q16.16 matrix per word, taken when mat_valid is
//   high and mat_stall is low. inv channel: nine inverse elements, the
//   determinant and a singular flag per word, taken when inv_valid is high
//   and inv_stall is low.
//   Pipeline: 10 front stages for the cofactor products and the exact
//   determinant, the first of them loaded at the accepting edge, 32
//   divider stages, one output register.
//   Throughput: one matrix per cycle while mat_stall is low. Each of the
//   nine lanes owns a pipelined restoring divider that retires one
//   quotient bit per stage.
//   Singular matrix (exact determinant zero): elements and determinant are
//   zero and singular is set.
//   Reset: all words in flight are dropped; inv_valid and mat_stall go low.
//   Receiver stall: the output register holds its word; one more word lands
//   in the skid register, then mat_stall rises and the pipe freezes until
//   the skid drains.
`default_nettype none

module matrix3x3_inverse (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           mat_valid,
    output logic                mat_stall,
    input  wire m3i_pkg::mat_t  mat,
    output logic                inv_valid,
    input  wire logic           inv_stall,
    output m3i_pkg::inv_t       inv
);

    localparam int N  = m3i_pkg::NLANE;
    localparam int FS = m3i_pkg::FRONT_STAGES;
    localparam int DS = m3i_pkg::DIV_STAGES;
    localparam int SP = FS + DS;

    typedef struct packed {
        logic [m3i_pkg::EW-1:0] det;
        logic                   sing;
    } side_t;

    logic                      en;
    logic [SP-1:0]             v_reg;
    m3i_pkg::lane_in_t         lin [N];
    logic [m3i_pkg::DMW-1:0]   f_dmag;
    logic [m3i_pkg::EW-1:0]    f_det;
    logic                      f_sing;
    logic [m3i_pkg::DMW-1:0]   d_feed [DS];
    logic [m3i_pkg::DMW-1:0]   dl_reg [DS-1];
    side_t                     sd_reg [DS];
    logic [m3i_pkg::EW-1:0]    lres [N];
    m3i_pkg::lane_in_t         lane_src [N];
    m3i_pkg::inv_t             p_item;
    m3i_pkg::inv_t             out_reg;
    m3i_pkg::inv_t             skid_reg;
    logic                      out_v_reg;
    logic                      skid_v_reg;
    logic                      out_free;
    logic                      p_take;

    // the whole pipe moves unless the skid word is parked
    assign en = !skid_v_reg;

    m3i_front u_front (
        .clk   (clk),
        .en    (en),
        .mat   (mat),
        .lin   (lin),
        .dmag  (f_dmag),
        .det_q (f_det),
        .sing  (f_sing)
    );

    // shared divisor line: every lane reads the same |det| per stage
    assign d_feed[0] = f_dmag;
    for (genvar j = 1; j < DS; j++)
    begin : g_dfeed
        assign d_feed[j] = dl_reg[j-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < DS - 1; j++)
                dl_reg[j] <= d_feed[j];
            sd_reg[0] <= '{det: f_det, sing: f_sing};
            for (int j = 1; j < DS; j++)
                sd_reg[j] <= sd_reg[j-1];
        end
    end

    // lane i*3+j computes r[i][j] from cofactor C[j][i]
    for (genvar i = 0; i < 3; i++)
    begin : g_row
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            assign lane_src[3*i+j] = lin[3*j+i];
            m3i_lane u_lane (
                .clk  (clk),
                .en   (en),
                .lin  (lane_src[3*i+j]),
                .d_in (d_feed),
                .res  (lres[3*i+j])
            );
        end
    end

    // merge: singular forces all elements to zero
    always_comb
    begin
        p_item.r00         = sd_reg[DS-1].sing ? '0 : lres[0];
        p_item.r01         = sd_reg[DS-1].sing ? '0 : lres[1];
        p_item.r02         = sd_reg[DS-1].sing ? '0 : lres[2];
        p_item.r10         = sd_reg[DS-1].sing ? '0 : lres[3];
        p_item.r11         = sd_reg[DS-1].sing ? '0 : lres[4];
        p_item.r12         = sd_reg[DS-1].sing ? '0 : lres[5];
        p_item.r20         = sd_reg[DS-1].sing ? '0 : lres[6];
        p_item.r21         = sd_reg[DS-1].sing ? '0 : lres[7];
        p_item.r22         = sd_reg[DS-1].sing ? '0 : lres[8];
        p_item.determinant = sd_reg[DS-1].det;
        p_item.singular    = sd_reg[DS-1].sing;
    end

    assign out_free = !out_v_reg || !inv_stall;
    assign p_take   = en && v_reg[SP-1];

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[SP-2:0], mat_valid};
    end

    // output register and skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
                out_v_reg <= p_take;
        end
        else if (p_take)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_v_reg)
                out_reg <= skid_reg;
            else if (p_take)
                out_reg <= p_item;
        end
        else if (p_take)
            skid_reg <= p_item;
    end

    assign mat_stall = skid_v_reg;
    assign inv_valid = out_v_reg;
    assign inv       = out_reg;

endmodule

`default_nettype wire

### sv/m3i_front.sv
// m3i_front: cofactor products, exact determinant and divider set-up.
// Depends on m3i_pkg.
`default_nettype none

module m3i_front (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire m3i_pkg::mat_t       mat,
    output m3i_pkg::lane_in_t        lin [m3i_pkg::NLANE],
    output logic [m3i_pkg::DMW-1:0]  dmag,
    output logic [m3i_pkg::EW-1:0]   det_q,
    output logic                     sing
);

    localparam int N = m3i_pkg::NLANE;

    logic signed [m3i_pkg::EW-1:0] a [N];

    assign a[0] = mat.a00;
    assign a[1] = mat.a01;
    assign a[2] = mat.a02;
    assign a[3] = mat.a10;
    assign a[4] = mat.a11;
    assign a[5] = mat.a12;
    assign a[6] = mat.a20;
    assign a[7] = mat.a21;
    assign a[8] = mat.a22;

    logic signed [63:0]  pa_reg [N];
    logic signed [63:0]  pb_reg [N];
    logic signed [31:0]  e0_reg [3];
    logic signed [31:0]  e1_reg [3];
    logic signed [64:0]  c_reg  [N];
    m3i_pkg::cof_t       cd_reg [2:8][N];
    logic [31:0]         emag_reg [3];
    logic                psgn2_reg [3];
    logic                psgn3_reg [3];
    logic                psgn4_reg [3];
    logic [63:0]         plo_reg [3];
    logic [63:0]         phi_reg [3];
    logic [95:0]         pm_reg [3];
    logic signed [96:0]  ps_reg [3];
    logic signed [96:0]  s01_reg;
    logic signed [96:0]  p2_reg;
    logic signed [96:0]  det_reg;
    logic                dneg_reg;
    logic                dzero_reg;
    logic [95:0]         dmag8_reg;
    m3i_pkg::lane_in_t   lin_reg [N];
    logic [95:0]         dmag_reg;
    logic [31:0]         detq_reg;
    logic                sing_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 0..1: cofactors as differences of two products
            for (int k = 0; k < N; k++)
            begin
                pa_reg[k] <= a[m3i_pkg::CX[k]] * a[m3i_pkg::CY[k]];
                pb_reg[k] <= a[m3i_pkg::CU[k]] * a[m3i_pkg::CV[k]];
                c_reg[k]  <= 65'(pa_reg[k]) - 65'(pb_reg[k]);
                cd_reg[2][k].mag <= c_reg[k][64] ? 64'(-c_reg[k]) : 64'(c_reg[k]);
                cd_reg[2][k].neg <= c_reg[k][64];
            end
            for (int s = 3; s <= 8; s++)
                for (int k = 0; k < N; k++)
                    cd_reg[s][k] <= cd_reg[s-1][k];
            // stages 2..5: first-row terms, 32x64 magnitudes in two halves
            for (int k = 0; k < 3; k++)
            begin
                e0_reg[k]    <= a[k];
                e1_reg[k]    <= e0_reg[k];
                emag_reg[k]  <= e1_reg[k][31] ? 32'(-e1_reg[k]) : 32'(e1_reg[k]);
                psgn2_reg[k] <= e1_reg[k][31] ^ c_reg[k][64];
                plo_reg[k]   <= emag_reg[k] * cd_reg[2][k].mag[31:0];
                phi_reg[k]   <= emag_reg[k] * cd_reg[2][k].mag[63:32];
                psgn3_reg[k] <= psgn2_reg[k];
                pm_reg[k]    <= 96'(plo_reg[k]) + {phi_reg[k], 32'd0};
                psgn4_reg[k] <= psgn3_reg[k];
                ps_reg[k]    <= psgn4_reg[k] ? -$signed({1'b0, pm_reg[k]})
                                             :  $signed({1'b0, pm_reg[k]});
            end
            // stages 6..8: determinant sum and magnitude
            s01_reg   <= ps_reg[0] + ps_reg[1];
            p2_reg    <= ps_reg[2];
            det_reg   <= s01_reg + p2_reg;
            dneg_reg  <= det_reg[96];
            dzero_reg <= (det_reg == '0);
            dmag8_reg <= det_reg[96] ? 96'(-det_reg) : 96'(det_reg);
            // stage 9: lane set-up; quotient overflows when |C| >= |det|
            for (int k = 0; k < N; k++)
            begin
                lin_reg[k].ovf  <= (96'(cd_reg[8][k].mag) >= dmag8_reg);
                lin_reg[k].rem  <= (96'(cd_reg[8][k].mag) >= dmag8_reg)
                                   ? '0 : 96'(cd_reg[8][k].mag);
                lin_reg[k].qneg <= cd_reg[8][k].neg ^ dneg_reg;
            end
            dmag_reg <= dmag8_reg;
            detq_reg <= m3i_pkg::sat_q(dneg_reg, |dmag8_reg[95:64], dmag8_reg[63:32]);
            sing_reg <= dzero_reg;
        end
    end

    assign lin   = lin_reg;
    assign dmag  = dmag_reg;
    assign det_q = detq_reg;
    assign sing  = sing_reg;

endmodule

`default_nettype wire

### sv/m3i_lane.sv
// m3i_lane: one divider lane, one restoring quotient bit per stage, then
// Q16.16 saturation. Depends on m3i_pkg.
`default_nettype none

module m3i_lane (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire m3i_pkg::lane_in_t      lin,
    input  wire logic [m3i_pkg::DMW-1:0] d_in [m3i_pkg::DIV_STAGES],
    output logic [m3i_pkg::EW-1:0]      res
);

    localparam int DS  = m3i_pkg::DIV_STAGES;
    localparam int DMW = m3i_pkg::DMW;
    localparam int QB  = m3i_pkg::QBITS;

    logic [DMW-1:0] rem_reg  [DS];
    logic [QB-1:0]  q_reg    [DS];
    logic           qneg_reg [DS];
    logic           ovf_reg  [DS];

    for (genvar j = 0; j < DS; j++)
    begin : g_step
        logic [DMW-1:0] rem_prev;
        logic [QB-1:0]  q_prev;
        logic           qneg_prev;
        logic           ovf_prev;
        logic [DMW:0]   t;
        logic [DMW:0]   diff;
        logic           ge;

        if (j == 0)
        begin : g_first
            assign rem_prev  = lin.rem;
            assign q_prev    = '0;
            assign qneg_prev = lin.qneg;
            assign ovf_prev  = lin.ovf;
        end
        else
        begin : g_next
            assign rem_prev  = rem_reg[j-1];
            assign q_prev    = q_reg[j-1];
            assign qneg_prev = qneg_reg[j-1];
            assign ovf_prev  = ovf_reg[j-1];
        end

        assign t    = {rem_prev, 1'b0};
        assign diff = t - {1'b0, d_in[j]};
        assign ge   = (t >= {1'b0, d_in[j]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= ge ? diff[DMW-1:0] : t[DMW-1:0];
                q_reg[j]    <= {q_prev[QB-2:0], ge};
                qneg_reg[j] <= qneg_prev;
                ovf_reg[j]  <= ovf_prev;
            end
        end
    end

    assign res = m3i_pkg::sat_q(qneg_reg[DS-1], ovf_reg[DS-1], q_reg[DS-1]);

endmodule

`default_nettype wire

### sv/m3i_checker.sv
// m3i_checker: port-level assertions for matrix3x3_inverse and the bind that
// attaches them. Depends on m3i_pkg.
`default_nettype none

module m3i_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          mat_valid,
    input wire logic          mat_stall,
    input wire m3i_pkg::mat_t mat,
    input wire logic          inv_valid,
    input wire logic          inv_stall,
    input wire m3i_pkg::inv_t inv
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv_stall |=> inv_valid && $stable(inv))
        else $error("stalled result word changed");

    // singular words carry zero elements and zero determinant
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv.singular |->
            inv.determinant == 0 && inv.r00 == 0 && inv.r01 == 0 && inv.r02 == 0 &&
            inv.r10 == 0 && inv.r11 == 0 && inv.r12 == 0 &&
            inv.r20 == 0 && inv.r21 == 0 && inv.r22 == 0)
        else $error("singular word with nonzero fields");

    a_reset: assert property (@(posedge clk) !rst_n |-> !inv_valid && !mat_stall)
        else $error("channels active during reset");

    // input back-pressure only while a result word is parked
    a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        mat_stall |-> inv_valid)
        else $error("input stalled with no result word");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mat_stall) |-> $past(inv_valid && inv_stall))
        else $error("input stall without receiver stall");

endmodule

bind matrix3x3_inverse m3i_checker u_m3i_checker (.*);

`default_nettype wire

### verif/matrix3x3_inverse_checker.sv
// Checker for matrix3x3_inverse: watches the mat and inv channels, predicts
// each inverse word, compares field by field. Depends on m3i_pkg.
`timescale 1ns / 100ps

module matrix3x3_inverse_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           mat_valid,
    input  logic           mat_stall,
    input  m3i_pkg::mat_t  mat,
    input  logic           inv_valid,
    input  logic           inv_stall,
    input  m3i_pkg::inv_t  inv,
    output int             fail_count,
    output int             pending
);

    m3i_pkg::inv_t expected_inv[$];
    int            fails = 0;
    int            depth = 0;

    assign fail_count = fails;
    assign pending    = depth;

    function automatic logic [31:0] clamp_q(input logic neg, input logic [127:0] mag);
        if (neg)
            return (mag > 128'h8000_0000) ? 32'h8000_0000 : 32'(-mag[31:0]);
        return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic m3i_pkg::inv_t invert(input m3i_pkg::mat_t m);
        logic signed [31:0]  e [9];
        logic signed [127:0] cf [9];
        logic signed [127:0] det;
        logic [127:0]        dmag, cmag, q;
        logic                qneg;
        m3i_pkg::inv_t       r;
        logic [31:0]         o [9];
        e = '{m.a00, m.a01, m.a02, m.a10, m.a11, m.a12, m.a20, m.a21, m.a22};
        cf[0] = 128'(e[4]) * e[8] - 128'(e[5]) * e[7];
        cf[1] = 128'(e[5]) * e[6] - 128'(e[3]) * e[8];
        cf[2] = 128'(e[3]) * e[7] - 128'(e[4]) * e[6];
        cf[3] = 128'(e[2]) * e[7] - 128'(e[1]) * e[8];
        cf[4] = 128'(e[0]) * e[8] - 128'(e[2]) * e[6];
        cf[5] = 128'(e[1]) * e[6] - 128'(e[0]) * e[7];
        cf[6] = 128'(e[1]) * e[5] - 128'(e[2]) * e[4];
        cf[7] = 128'(e[2]) * e[3] - 128'(e[0]) * e[5];
        cf[8] = 128'(e[0]) * e[4] - 128'(e[1]) * e[3];
        det = 128'(e[0]) * cf[0] + 128'(e[1]) * cf[1] + 128'(e[2]) * cf[2];
        r = '0;
        if (det == 0)
        begin
            r.singular = 1'b1;
            return r;
        end
        dmag = det[127] ? -det : det;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                // inverse (i,j) = cofactor (j,i) / det, shifted to Q16.16
                cmag = cf[3*j+i][127] ? -cf[3*j+i] : cf[3*j+i];
                q = (cmag << 32) / dmag;
                qneg = (cf[3*j+i][127] != det[127]) && q != 0;
                o[3*i+j] = clamp_q(qneg, q);
            end
        {r.r00, r.r01, r.r02, r.r10, r.r11, r.r12, r.r20, r.r21, r.r22} =
            {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8]};
        q = dmag >> 32;
        r.determinant = clamp_q(det[127] && q != 0, q);
        return r;
    endfunction

    task automatic cmp(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        m3i_pkg::inv_t want;
        if (rst_n && mat_valid && !mat_stall)
        begin
            want = invert(mat);
            expected_inv = {expected_inv, want};
        end
        if (rst_n && inv_valid && !inv_stall)
        begin
            if (expected_inv.size() == 0)
            begin
                $error("inv word with nothing expected");
                fails++;
            end
            else
            begin
                want = expected_inv.pop_front();
                cmp("r00", want.r00, inv.r00);
                cmp("r01", want.r01, inv.r01);
                cmp("r02", want.r02, inv.r02);
                cmp("r10", want.r10, inv.r10);
                cmp("r11", want.r11, inv.r11);
                cmp("r12", want.r12, inv.r12);
                cmp("r20", want.r20, inv.r20);
                cmp("r21", want.r21, inv.r21);
                cmp("r22", want.r22, inv.r22);
                cmp("determinant", want.determinant, inv.determinant);
                cmp("singular", 32'(want.singular), 32'(inv.singular));
            end
        end
        depth = expected_inv.size();
    end

endmodule

### verif/matrix3x3_inverse_test.sv
// Top of the matrix3x3_inverse testbench: clock, reset, matrix stimulus,
// receiver stalls and verdict. Depends on m3i_pkg and the checker.
`timescale 1ns / 100ps

module matrix3x3_inverse_test;

    localparam int LATENCY   = 43;
    localparam int N_RANDOM  = 2000;
    // every word waiting out max gap, max stall and the full pipe, many times over
    localparam int CYCLE_CAP = 400000;

    logic          clk;
    logic          rst_n;
    logic          mat_valid;
    logic          mat_stall;
    m3i_pkg::mat_t mat;
    logic          inv_valid;
    logic          inv_stall;
    m3i_pkg::inv_t inv;
    int            fail_count;
    int            pending;
    int            cycles;
    logic          stim_done;

    matrix3x3_inverse dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_stall (mat_stall),
        .mat       (mat),
        .inv_valid (inv_valid),
        .inv_stall (inv_stall),
        .inv       (inv)
    );

    matrix3x3_inverse_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .mat_valid  (mat_valid),
        .mat_stall  (mat_stall),
        .mat        (mat),
        .inv_valid  (inv_valid),
        .inv_stall  (inv_stall),
        .inv        (inv),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: per word, a random stall; some long runs with none
    initial
    begin
        int n;
        int calm;
        inv_stall = 1'b0;
        calm = 0;
        forever
        begin
            if (calm > 0)
            begin
                calm--;
                n = 0;
            end
            else
            begin
                n = $urandom_range(0, 15);
                if ($urandom_range(0, 40) == 0)
                    calm = $urandom_range(20, 100);
            end
            @(negedge clk);
            if (n > 0)
            begin
                inv_stall <= 1'b1;
                repeat (n) @(negedge clk);
                inv_stall <= 1'b0;
            end
            // hold low until a word is taken
            do
                @(posedge clk);
            while (!(inv_valid && rst_n));
        end
    end

    // Drive one matrix word; valid stays up across back-to-back words.
    task automatic send_matrix(input m3i_pkg::mat_t m, input int gap);
        if (gap > 0)
        begin
            mat_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mat       <= m;
        mat_valid <= 1'b1;
        do
            @(posedge clk);
        while (mat_stall);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_elem(input int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            2: return 32'($signed($urandom_range(0, 511)) - 256);
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic m3i_pkg::mat_t rand_matrix();
        m3i_pkg::mat_t m;
        int            kind;
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            // small well-conditioned values, usually invertible
            m = {rand_elem(1), rand_elem(1), rand_elem(1), rand_elem(1), rand_elem(1),
                 rand_elem(1), rand_elem(1), rand_elem(1), rand_elem(1)};
        end
        else if (kind < 6)
        begin
            m = {rand_elem(0), rand_elem(0), rand_elem(0), rand_elem(0), rand_elem(0),
                 rand_elem(0), rand_elem(0), rand_elem(0), rand_elem(0)};
        end
        else if (kind == 6)
        begin
            // tiny entries: tiny determinants and saturated inverses
            m = {rand_elem(2), rand_elem(2), rand_elem(2), rand_elem(2), rand_elem(2),
                 rand_elem(2), rand_elem(2), rand_elem(2), rand_elem(2)};
        end
        else if (kind == 7)
        begin
            // singular: row 2 copies row 0 or row 1
            m = {rand_elem(1), rand_elem(1), rand_elem(1), rand_elem(0), rand_elem(0),
                 rand_elem(0), 96'd0};
            if ($urandom_range(0, 1))
                {m.a20, m.a21, m.a22} = {m.a00, m.a01, m.a02};
            else
                {m.a20, m.a21, m.a22} = {m.a10, m.a11, m.a12};
        end
        else if (kind == 8)
        begin
            // diagonal with random extremes mixed in
            m = '0;
            m.a00 = rand_elem($urandom_range(0, 3));
            m.a11 = rand_elem($urandom_range(0, 3));
            m.a22 = rand_elem($urandom_range(0, 3));
        end
        else
        begin
            m = {rand_elem($urandom_range(0, 3)), rand_elem($urandom_range(0, 3)),
                 rand_elem($urandom_range(0, 3)), rand_elem($urandom_range(0, 3)),
                 rand_elem($urandom_range(0, 3)), rand_elem($urandom_range(0, 3)),
                 rand_elem($urandom_range(0, 3)), rand_elem($urandom_range(0, 3)),
                 rand_elem($urandom_range(0, 3))};
        end
        return m;
    endfunction

    initial
    begin
        m3i_pkg::mat_t directed[$];
        m3i_pkg::mat_t m;
        int            gap;
        int            calm;
        rst_n     = 1'b0;
        mat_valid = 1'b0;
        mat       = '0;
        stim_done = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // identity, a mixed diagonal, zero, all-max, all-min
        m = '0; m.a00 = 32'h1_0000; m.a11 = 32'h1_0000; m.a22 = 32'h1_0000;
        directed = {directed, m};
        m.a00 = 32'h2_0000; m.a11 = 32'hFFFF_8000; m.a22 = 32'h4_0000;
        directed = {directed, m};
        m = '0;
        directed = {directed, m};
        m = {9{32'h7FFF_FFFF}};
        directed = {directed, m};
        m = {9{32'h8000_0000}};
        directed = {directed, m};
        // extreme diagonals: determinant saturates to the most negative value
        m = '0; m.a00 = 32'h7FFF_FFFF; m.a11 = 32'h7FFF_FFFF; m.a22 = 32'h8000_0000;
        directed = {directed, m};
        m = '0; m.a00 = 32'h8000_0000; m.a11 = 32'h8000_0000; m.a22 = 32'h8000_0000;
        directed = {directed, m};
        // tiny determinant: 1 lsb on the diagonal
        m = '0; m.a00 = 32'd1; m.a11 = 32'd1; m.a22 = 32'd1;
        directed = {directed, m};
        m.a22 = 32'hFFFF_FFFF;
        directed = {directed, m};
        // permutation and a general invertible matrix
        m = '0; m.a01 = 32'h1_0000; m.a12 = 32'h1_0000; m.a20 = 32'h1_0000;
        directed = {directed, m};
        m = {32'h2_0000, 32'h1_0000, 32'h0, 32'h1_0000, 32'h3_0000, 32'h1_0000,
             32'h0, 32'h1_0000, 32'h4_0000};
        directed = {directed, m};
        // singular: rank one and rank two
        m = {9{32'h1_0000}};
        directed = {directed, m};
        m = {32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000, 32'h5_0000, 32'h6_0000,
             32'h7_0000, 32'h8_0000, 32'h9_0000};
        directed = {directed, m};
        // alternating bit patterns
        m = {9{32'hAAAA_AAAA}};
        directed = {directed, m};
        m = {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
             32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001,
             32'h5555_5555, 32'hFFFF_FFFE, 32'h5555_5555};
        directed = {directed, m};
        foreach (directed[k])
            send_matrix(directed[k], $urandom_range(0, 3));

        calm = 0;
        for (int k = 0; k < N_RANDOM; k++)
        begin
            // halfway: hold off until the pipe is fully drained
            if (k == N_RANDOM / 2)
            begin
                mat_valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            if (calm > 0)
            begin
                calm--;
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, 15);
                if ($urandom_range(0, 30) == 0)
                    calm = $urandom_range(30, 150);
            end
            send_matrix(rand_matrix(), gap);
        end
        mat_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // verdict once everything expected has come and the pipe has settled
    initial
    begin
        wait (stim_done);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
